@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the bin allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define BFTA_ASSERT_AT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the usual clk_i and rst_ni of the enclosing module.
`define BFTA_ASSERT(name, prop, msg) \
  `BFTA_ASSERT_AT(name, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/bfta_pkg.sv @@
// Shared types, sizes and codes of the best-fit tagged bin allocator.
package bfta_pkg;

  localparam int BINS       = 64;
  localparam int CAP_BITS   = 4;
  localparam int SLOT_W     = $clog2(BINS);
  localparam int CNT_W      = $clog2(BINS + 1);
  localparam int ID_W       = 16;
  localparam int CLS_W      = 4;
  localparam int OUT_SLOT_W = 6;
  localparam int S_TDATA_W  = 24;
  localparam int M_TDATA_W  = 32;

  typedef enum logic [1:0] {
    FN_APPEND = 2'd0,
    FN_ALLOC  = 2'd1,
    FN_CLEAR  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_NO_FIT = 2'd1,
    STS_FULL   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_INC   = 2'd2
  } cmd_op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_FIN  = 2'd2
  } state_e;

  // Update broadcast to every cell; only the cell whose slot matches acts.
  typedef struct packed {
    cmd_op_e               op;
    logic [SLOT_W-1:0]     slot;
    logic [ID_W-1:0]       id;
    logic [CAP_BITS-1:0]   cap;
    logic [CLS_W-1:0]      cls;
  } cmd_t;

  // Search token handed from cell to cell, carrying the best bin so far.
  typedef struct packed {
    logic                  valid;
    logic                  found;
    logic [CAP_BITS-1:0]   fill;
    logic [SLOT_W-1:0]     slot;
    logic [ID_W-1:0]       id;
  } tok_t;

endpackage

@@ rtl/bfta_cell.sv @@
// One table cell: holds one bin and refines the passing search token.
module bfta_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [bfta_pkg::SLOT_W-1:0]  slot_i,
  input  logic [bfta_pkg::CNT_W-1:0]   count_i,
  input  logic [bfta_pkg::CLS_W-1:0]   req_class_i,
  input  bfta_pkg::cmd_t               cmd_i,
  input  bfta_pkg::tok_t               tok_i,
  output bfta_pkg::tok_t               tok_o
);
  import bfta_pkg::*;

  logic [ID_W-1:0]     id_q;
  logic [CAP_BITS-1:0] cap_q;
  logic [CLS_W-1:0]    cls_q;
  logic [CAP_BITS-1:0] fill_q;
  logic                hit;
  logic                in_use;
  logic                candidate;
  tok_t                tok_d;
  tok_t                tok_q;

  assign hit    = (cmd_i.slot == slot_i);
  assign in_use = (CNT_W'(slot_i) < count_i);

  // A bin qualifies when it is in use, has room and its class matches.
  assign candidate = in_use && (fill_q < cap_q) &&
                     ((cls_q == '0) || (req_class_i == '0) || (cls_q == req_class_i));

  always_comb begin
    tok_d = tok_i;
    // Strictly greater keeps the earliest bin on a tie.
    if (tok_i.valid && candidate && (!tok_i.found || (fill_q > tok_i.fill))) begin
      tok_d.found = 1'b1;
      tok_d.fill  = fill_q;
      tok_d.slot  = slot_i;
      tok_d.id    = id_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit && (cmd_i.op == CMD_WRITE)) begin
      id_q   <= cmd_i.id;
      cap_q  <= cmd_i.cap;
      cls_q  <= cmd_i.cls;
      fill_q <= '0;
    end else if (hit && (cmd_i.op == CMD_INC)) begin
      fill_q <= fill_q + CAP_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

@@ rtl/best_fit_tagged_bin_allocator.sv @@
// Top level of the best-fit tagged bin allocator: control, chain of cells, output word.
//
// The block keeps a table of up to 64 bins, each with an identifier, a capacity,
// a class tag and a fill count. Commands arrive as words on the s_axis channel
// (operation in tuser, bin fields in tdata) and every command yields exactly one
// result word on the m_axis channel. Append places a new bin at the next free
// slot, allocate picks the matching bin with room and the highest fill (earliest
// slot on a tie) and bumps its fill, and clear empties the table.
// The table lives in a row of 64 cells. An allocate sends a search token down
// the row, one cell per clock; once the token has crossed all 64 cells the
// winning token is latched, and the final state then writes the chosen fill back
// and loads the result once the output register is free. Append, clear and the
// unused operation code go straight to the final state and load their result
// there. One command is handled at a time; the block is ready for the next word
// as soon as the result sits in the output register, and takes none before then.
// Reset empties the table (the bin count goes to zero) and drops any pending
// result; stored bin contents are not cleared, since only slots below the count
// are ever looked at. If the receiver stalls, the result word is held steady
// and a finished command waits in its last state until the register frees up.
module best_fit_tagged_bin_allocator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata fields from bit 0: bin_id[15:0], bin_capacity[19:16], class_code[23:20]
  input  logic [bfta_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // tuser fields from bit 0: func[1:0]
  input  logic [1:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata fields from bit 0: status[1:0], chosen_id[17:2], chosen_slot[23:18],
  // fill_after[27:24], zero padding[31:28]
  output logic [bfta_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
  import bfta_pkg::*;

  state_e              state_q, state_d;
  logic                s_fire;
  logic                out_free;
  logic                fin_fire;

  // Request captured at acceptance.
  func_e               req_func_q;
  logic [ID_W-1:0]     req_id_q;
  logic [CAP_BITS-1:0] req_cap_q;
  logic [CLS_W-1:0]    req_cls_q;

  logic [CNT_W-1:0]    count_q, count_d;
  logic                launch_q;
  tok_t                chain [BINS+1];
  tok_t                best_q;
  cmd_t                cmd;

  // Result fields of the command in its final state.
  status_e             res_status;
  logic [ID_W-1:0]     res_id;
  logic [OUT_SLOT_W-1:0] res_slot;
  logic [CAP_BITS-1:0] res_fill;

  logic                m_valid_q;
  logic [M_TDATA_W-1:0] m_data_q;

  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          state_d = (func_e'(s_axis_tuser) == FN_ALLOC) ? ST_SCAN : ST_FIN;
        end
      end
      ST_SCAN: begin
        if (chain[BINS].valid) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output and command logic.
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    fin_fire      = (state_q == ST_FIN) && out_free;
    cmd           = '0;
    cmd.op        = CMD_NONE;
    count_d       = count_q;
    res_status    = STS_OK;
    res_id        = '0;
    res_slot      = '0;
    res_fill      = '0;
    unique case (req_func_q)
      FN_APPEND: begin
        if (count_q == CNT_W'(BINS)) begin
          res_status = STS_FULL;
        end else begin
          res_slot = OUT_SLOT_W'(count_q[SLOT_W-1:0]);
          if (fin_fire) begin
            cmd.op   = CMD_WRITE;
            cmd.slot = count_q[SLOT_W-1:0];
            cmd.id   = req_id_q;
            cmd.cap  = req_cap_q;
            cmd.cls  = req_cls_q;
            count_d  = count_q + CNT_W'(1);
          end
        end
      end
      FN_ALLOC: begin
        if (best_q.found) begin
          res_id   = best_q.id;
          res_slot = OUT_SLOT_W'(best_q.slot);
          res_fill = best_q.fill + CAP_BITS'(1);
          if (fin_fire) begin
            cmd.op   = CMD_INC;
            cmd.slot = best_q.slot;
          end
        end else begin
          res_status = STS_NO_FIT;
        end
      end
      FN_CLEAR: begin
        if (fin_fire) begin
          count_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      launch_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      launch_q <= s_fire && (func_e'(s_axis_tuser) == FN_ALLOC);
      if (fin_fire) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      req_func_q <= func_e'(s_axis_tuser);
      req_id_q   <= s_axis_tdata[ID_W-1:0];
      req_cap_q  <= CAP_BITS'(s_axis_tdata[19:16]);
      req_cls_q  <= s_axis_tdata[23:20];
    end
    if ((state_q == ST_SCAN) && chain[BINS].valid) begin
      best_q <= chain[BINS];
    end
    if (fin_fire) begin
      m_data_q <= {4'b0000, 4'(res_fill), res_slot, res_id, res_status};
    end
  end

  // The token enters the first cell in the cycle after an allocate is accepted.
  always_comb begin
    chain[0]       = '0;
    chain[0].valid = launch_q;
  end

  for (genvar i = 0; i < BINS; i++) begin : g_cell
    bfta_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .slot_i      (SLOT_W'(i)),
      .count_i     (count_q),
      .req_class_i (req_cls_q),
      .cmd_i       (cmd),
      .tok_i       (chain[i]),
      .tok_o       (chain[i+1])
    );
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

@@ rtl/bfta_checker.sv @@
// Port-level checker for the bin allocator and its bind to the top level.
`include "assert_macros.svh"

module bfta_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [bfta_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
  import bfta_pkg::*;

  logic       in_fire;
  logic       out_stall;
  logic [1:0] out_status;

  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign out_stall  = m_axis_tvalid && !m_axis_tready;
  assign out_status = m_axis_tdata[1:0];

  // A stalled result word must not change.
  `BFTA_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata), "word changed")

  // Status is always one of the three defined codes.
  `BFTA_ASSERT(a_status_code, m_axis_tvalid |-> out_status != 2'd3, "undefined status code")

  // A failed command reports zeros in every other field and the padding.
  `BFTA_ASSERT(a_fail_zero, m_axis_tvalid && out_status != 2'd0 |-> m_axis_tdata[31:2] == '0, "bad fail")

  // Only one command is in flight: the block is busy right after taking one.
  `BFTA_ASSERT(a_one_in_flight, in_fire |=> !s_axis_tready, "input taken while busy")

endmodule

bind best_fit_tagged_bin_allocator bfta_checker u_bfta_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ bench/best_fit_tagged_bin_allocator_test.sv @@
// Self-checking bench for the best-fit tagged bin allocator: a directed table, then random streams.
module best_fit_tagged_bin_allocator_test;
  import bfta_pkg::*;

  // Operation code that the block must answer with an all-zero ok word.
  localparam logic [1:0] FN_UNUSED = 2'd3;

  localparam int unsigned RANDOM_WORDS = 1400;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam int unsigned MAX_REPORTS  = 100;

  typedef struct packed {
    status_e                 status;
    logic [ID_W-1:0]         id;
    logic [OUT_SLOT_W-1:0]   slot;
    logic [CAP_BITS-1:0]     fill;
  } alloc_result_t;

  // One command word; typed rows carry a hand-written result that replaces the prediction.
  typedef struct packed {
    logic [1:0]              func;
    logic [ID_W-1:0]         id;
    logic [CAP_BITS-1:0]     cap;
    logic [CLS_W-1:0]        cls;
    logic                    typed;
    alloc_result_t           want;
  } command_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
  logic [1:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata;

  // Shadow copy of the bin table.
  logic [ID_W-1:0]        tbl_id   [BINS];
  logic [CAP_BITS-1:0]    tbl_cap  [BINS];
  logic [CLS_W-1:0]       tbl_cls  [BINS];
  logic [CAP_BITS-1:0]    tbl_fill [BINS];
  int unsigned            tbl_count = 0;

  alloc_result_t          pending_results [$];
  command_t               directed_rows [$];
  int unsigned            words_sent = 0;
  int unsigned            mismatch_count = 0;
  int unsigned            cycle_count = 0;
  bit                     send_quiet = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  best_fit_tagged_bin_allocator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Applies one command to the shadow table and returns the word the block should send.
  function automatic alloc_result_t apply_command(input command_t c);
    alloc_result_t res;
    logic          found;
    int unsigned   best;
    res = '0;
    res.status = STS_OK;
    found = 1'b0;
    best = 0;
    if (c.func == FN_APPEND) begin
      if (tbl_count >= BINS) begin
        res.status = STS_FULL;
      end else begin
        tbl_id[tbl_count]   = c.id;
        tbl_cap[tbl_count]  = c.cap;
        tbl_cls[tbl_count]  = c.cls;
        tbl_fill[tbl_count] = '0;
        res.slot = OUT_SLOT_W'(tbl_count);
        tbl_count++;
      end
    end else if (c.func == FN_ALLOC) begin
      // Best fit: the fullest bin that still has room, earliest slot on a tie.
      for (int unsigned i = 0; i < tbl_count; i++) begin
        if (tbl_fill[i] < tbl_cap[i] &&
            (tbl_cls[i] == '0 || c.cls == '0 || tbl_cls[i] == c.cls)) begin
          if (!found || tbl_fill[i] > tbl_fill[best]) begin
            best = i;
            found = 1'b1;
          end
        end
      end
      if (found) begin
        tbl_fill[best] = tbl_fill[best] + 1'b1;
        res.id   = tbl_id[best];
        res.slot = OUT_SLOT_W'(best);
        res.fill = tbl_fill[best];
      end else begin
        res.status = STS_NO_FIT;
      end
    end else if (c.func == FN_CLEAR) begin
      tbl_count = 0;
    end
    return res;
  endfunction

  // Small capacities and few classes keep bins filling up and requests colliding.
  function automatic command_t random_command(input logic [1:0] func);
    command_t c;
    c = '0;
    c.func = func;
    c.id   = ID_W'($urandom);
    c.cap  = ($urandom_range(0, 4) == 0) ? CAP_BITS'($urandom_range(0, 15))
                                         : CAP_BITS'($urandom_range(0, 4));
    c.cls  = ($urandom_range(0, 3) == 0) ? CLS_W'($urandom_range(0, 15))
                                         : CLS_W'($urandom_range(0, 3));
    return c;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic put_row(input logic [1:0] func, input logic [ID_W-1:0] id,
                         input logic [CAP_BITS-1:0] cap, input logic [CLS_W-1:0] cls,
                         input logic typed, input status_e status,
                         input logic [ID_W-1:0] rid, input logic [OUT_SLOT_W-1:0] slot,
                         input logic [CAP_BITS-1:0] fill);
    command_t c;
    c.func = func;
    c.id = id;
    c.cap = cap;
    c.cls = cls;
    c.typed = typed;
    c.want.status = status;
    c.want.id = rid;
    c.want.slot = slot;
    c.want.fill = fill;
    directed_rows.push_back(c);
  endtask

  // Presents one word, waits for the handshake, records its expected result, then may idle.
  task automatic issue_command(input command_t c);
    alloc_result_t predicted;
    int unsigned   gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c.cls, c.cap, c.id};
    s_axis_tuser  <= c.func;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = apply_command(c);
    pending_results.push_back(c.typed ? c.want : predicted);
    words_sent++;
    gap = pick_gap(send_quiet);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
    if (mismatch_count < MAX_REPORTS)
      $display("mismatch on %s: expected 0x%0h, got 0x%0h", what, want, got);
    mismatch_count++;
  endtask

  // Result checker: every accepted word is matched against the oldest expectation.
  always @(posedge clk_i) begin : check_output
    alloc_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", 0, m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[1:0] !== want.status)
          report_mismatch("status", want.status, m_axis_tdata[1:0]);
        if (m_axis_tdata[17:2] !== want.id)
          report_mismatch("chosen_id", want.id, m_axis_tdata[17:2]);
        if (m_axis_tdata[23:18] !== want.slot)
          report_mismatch("chosen_slot", want.slot, m_axis_tdata[23:18]);
        if (m_axis_tdata[27:24] !== want.fill)
          report_mismatch("fill_after", want.fill, m_axis_tdata[27:24]);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver pacing: short ready bursts broken by stalls, with stall-free stretches.
  initial begin : sink_pacing
    int unsigned hold;
    int unsigned stall;
    bit          quiet;
    quiet = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) quiet = !quiet;
      m_axis_tready <= 1'b1;
      hold = $urandom_range(1, 8);
      repeat (hold) @(posedge clk_i);
      stall = pick_gap(quiet);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    command_t    c;
    int unsigned n_append;
    int unsigned n_alloc;
    int unsigned r;

    // Empty table, extreme fields, zero capacity, wildcard classes, exhaustion.
    put_row(FN_ALLOC,  16'h0000, 4'h0, 4'h0, 1'b1, STS_NO_FIT, 16'h0000, 6'd0, 4'd0);
    put_row(FN_APPEND, 16'hFFFF, 4'hF, 4'hF, 1'b1, STS_OK,     16'h0000, 6'd0, 4'd0);
    put_row(FN_APPEND, 16'h0000, 4'h0, 4'h0, 1'b1, STS_OK,     16'h0000, 6'd1, 4'd0);
    put_row(FN_APPEND, 16'h1234, 4'h1, 4'h3, 1'b1, STS_OK,     16'h0000, 6'd2, 4'd0);
    put_row(FN_APPEND, 16'hABCD, 4'h2, 4'h0, 1'b1, STS_OK,     16'h0000, 6'd3, 4'd0);
    put_row(FN_ALLOC,  16'h5555, 4'h5, 4'h5, 1'b0, STS_OK,     16'h0000, 6'd0, 4'd0);
    put_row(FN_ALLOC,  16'hAAAA, 4'hA, 4'h5, 1'b0, STS_OK,     16'h0000, 6'd0, 4'd0);
    put_row(FN_ALLOC,  16'h0000, 4'h0, 4'h5, 1'b1, STS_NO_FIT, 16'h0000, 6'd0, 4'd0);
    put_row(FN_ALLOC,  16'h0000, 4'h0, 4'h0, 1'b0, STS_OK,     16'h0000, 6'd0, 4'd0);
    put_row(FN_ALLOC,  16'h0000, 4'h0, 4'h3, 1'b0, STS_OK,     16'h0000, 6'd0, 4'd0);
    put_row(FN_ALLOC,  16'hFFFF, 4'hF, 4'hF, 1'b0, STS_OK,     16'h0000, 6'd0, 4'd0);
    put_row(FN_UNUSED, 16'h5A5A, 4'h7, 4'h9, 1'b1, STS_OK,     16'h0000, 6'd0, 4'd0);
    put_row(FN_CLEAR,  16'hFFFF, 4'hF, 4'hF, 1'b1, STS_OK,     16'h0000, 6'd0, 4'd0);
    put_row(FN_ALLOC,  16'h0000, 4'h0, 4'h0, 1'b1, STS_NO_FIT, 16'h0000, 6'd0, 4'd0);
    put_row(FN_APPEND, 16'h8001, 4'hF, 4'h1, 1'b1, STS_OK,     16'h0000, 6'd0, 4'd0);
    put_row(FN_ALLOC,  16'h0000, 4'h0, 4'h1, 1'b0, STS_OK,     16'h0000, 6'd0, 4'd0);
    put_row(FN_ALLOC,  16'h0000, 4'h0, 4'h2, 1'b1, STS_NO_FIT, 16'h0000, 6'd0, 4'd0);
    put_row(FN_ALLOC,  16'h0000, 4'h0, 4'h0, 1'b0, STS_OK,     16'h0000, 6'd0, 4'd0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) issue_command(directed_rows[k]);

    // Run the table past full once so the full status shows up early.
    issue_command(random_command(FN_CLEAR));
    repeat (BINS + 4) issue_command(random_command(FN_APPEND));
    repeat (20) issue_command(random_command(FN_ALLOC));

    // Random phases: an optional clear, a burst of appends, then mostly allocates
    // with a sprinkling of stray appends, clears and the unused code.
    while (words_sent < RANDOM_WORDS) begin
      send_quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) issue_command(random_command(FN_CLEAR));
      n_append = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 10);
      n_alloc  = $urandom_range(1, 50);
      repeat (n_append) issue_command(random_command(FN_APPEND));
      repeat (n_alloc) begin
        r = $urandom_range(0, 99);
        if (r < 3)      c = random_command(FN_UNUSED);
        else if (r < 6) c = random_command(FN_APPEND);
        else if (r < 7) c = random_command(FN_CLEAR);
        else            c = random_command(FN_ALLOC);
        issue_command(c);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
